/* rtl/lpht_pkg.sv */
// Types, status codes and hash constants shared by the hash table files.
package lpht_pkg;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_ZERO = 2'd3;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    localparam logic [63:0] MIX_ADD  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL1 = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL2 = 64'h94D0_49BB_1331_11EB;
    localparam int MIX_SHIFT1 = 30;
    localparam int MIX_SHIFT2 = 27;
    localparam int MIX_SHIFT3 = 31;

    typedef struct packed {
        logic        opcode;
        logic [63:0] lookup_key;
        logic [31:0] in_identity;
        logic [31:0] in_flags;
        logic [63:0] in_label_digest;
        logic [63:0] in_timestamp;
    } lpht_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_identity;
        logic [31:0] out_flags;
        logic [63:0] out_label_digest;
        logic [63:0] out_timestamp;
    } lpht_rsp_t;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] identity;
        logic [31:0] flags;
        logic [63:0] label_digest;
        logic [63:0] timestamp;
    } lpht_entry_t;

endpackage

/* rtl/lpht_stream_if.sv */
// Valid/ready channel that carries one item of a given payload type.
interface lpht_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/lpht_mix.sv */
// Multi-cycle splitmix64 finaliser on one shared 32 by 32 multiplier, giving the home slot.
module lpht_mix
    import lpht_pkg::*;
#(
    parameter int SLOT_BITS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [63:0]          key,
    output logic                 done,
    output logic [SLOT_BITS-1:0] slot
);

    localparam logic [2:0] H_IDLE = 3'd0;
    localparam logic [2:0] H_P0   = 3'd1;
    localparam logic [2:0] H_P1   = 3'd2;
    localparam logic [2:0] H_P2   = 3'd3;
    localparam logic [2:0] H_MIX  = 3'd4;
    localparam logic [2:0] H_FIN  = 3'd5;

    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic        round_reg;
    logic [63:0] x_reg;
    logic [63:0] acc_reg;
    logic [63:0] seed;
    logic [63:0] mul_const;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic [63:0] fin;

    assign seed      = key + MIX_ADD;
    assign mul_const = round_reg ? MIX_MUL2 : MIX_MUL1;
    assign mul_a     = (phase_reg == H_P1) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b     = (phase_reg == H_P2) ? mul_const[63:32] : mul_const[31:0];
    assign prod      = {32'd0, mul_a} * {32'd0, mul_b};
    assign fin       = acc_reg ^ (acc_reg >> MIX_SHIFT3);

    assign done = (phase_reg == H_FIN);
    assign slot = fin[SLOT_BITS-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            H_IDLE:  phase_next = start ? H_P0 : H_IDLE;
            H_P0:    phase_next = H_P1;
            H_P1:    phase_next = H_P2;
            H_P2:    phase_next = round_reg ? H_FIN : H_MIX;
            H_MIX:   phase_next = H_P0;
            H_FIN:   phase_next = H_IDLE;
            default: phase_next = H_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= H_IDLE;
            round_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (phase_reg == H_IDLE)
            begin
                round_reg <= 1'b0;
            end
            else if (phase_reg == H_MIX)
            begin
                round_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (phase_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    x_reg <= seed ^ (seed >> MIX_SHIFT1);
                end
            end
            H_P0:
            begin
                acc_reg <= prod;
            end
            H_P1, H_P2:
            begin
                acc_reg <= acc_reg + {prod[31:0], 32'd0};
            end
            H_MIX:
            begin
                x_reg <= acc_reg ^ (acc_reg >> MIX_SHIFT2);
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* rtl/linear_probe_hash_table_top.sv */
// Top level of the linear-probing hash table: channels, slot memory and probe control.
// After reset the block clears its slot memory, one slot a cycle, before it takes the first
// item. It then works on one item at a time: a request with key zero skips the hash and the
// probe. The hash shares one 32 by 32 multiplier over both multiplications of the finaliser;
// the probe then reads one slot a cycle from the single slot memory, and each read is
// registered before it is compared. A result waits in an output register, and the next item
// can be taken while it waits.
module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int SLOT_BITS = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    lpht_stream_if.sink   req,
    lpht_stream_if.source rsp
);

    localparam int SLOT_COUNT = 1 << SLOT_BITS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_PROBE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    lpht_entry_t mem [SLOT_COUNT];

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [SLOT_BITS-1:0] clr_addr_reg;
    logic [SLOT_BITS:0]   issue_cnt_reg;
    logic [SLOT_BITS-1:0] probe_addr_reg;
    logic [SLOT_BITS-1:0] rd_slot_reg;
    logic                 rd_valid_reg;
    logic                 rd_last_reg;
    lpht_entry_t          rd_data_reg;
    lpht_req_t            req_reg;
    logic [1:0]           status_reg;
    logic                 hit_reg;
    logic                 rsp_valid_reg;
    lpht_rsp_t            rsp_data_reg;

    logic                 req_take;
    logic                 hash_start;
    logic                 hash_done;
    logic [SLOT_BITS-1:0] hash_slot;
    logic                 issuing;
    logic                 key_hit;
    logic                 key_empty;
    logic                 is_insert;
    logic                 decide;
    logic [1:0]           decide_status;
    logic                 decide_hit;
    logic                 rsp_free;
    logic                 mem_we;
    logic                 mem_re;
    logic [SLOT_BITS-1:0] mem_waddr;
    lpht_entry_t          mem_wdata;

    assign req.ready  = (state_reg == S_IDLE);
    assign req_take   = req.valid && req.ready;
    assign hash_start = req_take && (req.data.lookup_key != 64'd0);

    lpht_mix #(
        .SLOT_BITS (SLOT_BITS)
    ) u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (req.data.lookup_key),
        .done  (hash_done),
        .slot  (hash_slot)
    );

    assign is_insert = (req_reg.opcode == OP_INSERT);
    assign key_hit   = (rd_data_reg.key == req_reg.lookup_key);
    assign key_empty = (rd_data_reg.key == 64'd0);
    assign decide    = (state_reg == S_PROBE) && rd_valid_reg
                       && (key_hit || key_empty || rd_last_reg);
    assign issuing   = (issue_cnt_reg != (SLOT_BITS + 1)'(SLOT_COUNT));
    assign mem_re    = (state_reg == S_PROBE) && issuing && !decide;

    always_comb
    begin
        decide_hit = 1'b0;
        if (is_insert)
        begin
            decide_status = (key_hit || key_empty) ? ST_OK : ST_FULL;
        end
        else if (key_hit)
        begin
            decide_status = ST_OK;
            decide_hit    = 1'b1;
        end
        else
        begin
            decide_status = ST_MISS;
        end
    end

    // The cleared entry needs only a zero key; the record fields are zeroed with it.
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we                 = decide && is_insert && (key_hit || key_empty);
            mem_waddr              = rd_slot_reg;
            mem_wdata.key          = req_reg.lookup_key;
            mem_wdata.identity     = req_reg.in_identity;
            mem_wdata.flags        = req_reg.in_flags;
            mem_wdata.label_digest = req_reg.in_label_digest;
            mem_wdata.timestamp    = req_reg.in_timestamp;
        end
    end

    assign rsp_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == {SLOT_BITS{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_take)
                begin
                    state_next = hash_start ? S_HASH : S_DONE;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (decide)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            issue_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + SLOT_BITS'(1);
            end
            if (state_reg == S_HASH)
            begin
                issue_cnt_reg <= '0;
                rd_valid_reg  <= 1'b0;
            end
            else if (state_reg == S_PROBE)
            begin
                rd_valid_reg <= mem_re;
                if (mem_re)
                begin
                    issue_cnt_reg <= issue_cnt_reg + (SLOT_BITS + 1)'(1);
                end
            end
            if ((state_reg == S_DONE) && rsp_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg    <= req.data;
            status_reg <= ST_ZERO;
            hit_reg    <= 1'b0;
        end
        if ((state_reg == S_HASH) && hash_done)
        begin
            probe_addr_reg <= hash_slot;
        end
        if (mem_re)
        begin
            probe_addr_reg <= probe_addr_reg + SLOT_BITS'(1);
            rd_slot_reg    <= probe_addr_reg;
            rd_last_reg    <= (issue_cnt_reg == (SLOT_BITS + 1)'(SLOT_COUNT - 1));
        end
        if (decide)
        begin
            status_reg <= decide_status;
            hit_reg    <= decide_hit;
        end
        if ((state_reg == S_DONE) && rsp_free)
        begin
            rsp_data_reg.status <= status_reg;
            if (hit_reg)
            begin
                rsp_data_reg.out_identity     <= rd_data_reg.identity;
                rsp_data_reg.out_flags        <= rd_data_reg.flags;
                rsp_data_reg.out_label_digest <= rd_data_reg.label_digest;
                rsp_data_reg.out_timestamp    <= rd_data_reg.timestamp;
            end
            else
            begin
                rsp_data_reg.out_identity     <= 32'd0;
                rsp_data_reg.out_flags        <= 32'd0;
                rsp_data_reg.out_label_digest <= 64'd0;
                rsp_data_reg.out_timestamp    <= 64'd0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[probe_addr_reg];
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule
